>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on clk and disabled in rst
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> rtl/core/bfbp_pkg.sv
// ----------------------------------------------------------------------------
// bfbp_pkg
// Types and constants shared by the best-fit block placer modules
// ----------------------------------------------------------------------------
package bfbp_pkg;

  // field widths fixed by the item format
  localparam int INDEX_W  = 4;
  localparam int AMOUNT_W = 16;
  localparam int CFG_W    = 5;
  localparam int TDATA_W  = 24;
  localparam int TDATA_PAD = TDATA_W - INDEX_W - AMOUNT_W;

  // apb register map
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;
  localparam logic REG_IDX_BLOCKS = 1'b0;
  localparam logic [CFG_W-1:0] BLOCKS_RESET = 5'd16;

  // tuser codes on the input side
  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_REQ  = 1'b1;

  typedef struct packed {
    logic load_wr;    // write a free size from the input beat
    logic req_start;  // capture request amount, clear best candidate
    logic rd_en;      // read table entry at rd_addr
    logic finish;     // write back best entry, load output register
  } cmd_t;

  typedef struct packed {
    logic out_free;   // output register empty or draining this cycle
  } stat_t;

endpackage

>>> rtl/core/bfbp_ctrl.sv
// ----------------------------------------------------------------------------
// bfbp_ctrl
// Sequencer: accepts beats, steps the table scan, hands the result off
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bfbp_ctrl #(
  parameter int MAX_BLOCKS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  input  logic                        s_tuser,
  output logic                        s_tready,
  input  logic [bfbp_pkg::CFG_W-1:0]  blocks_in_use,
  input  bfbp_pkg::stat_t             stat,
  output bfbp_pkg::cmd_t              cmd,
  output logic [$clog2(MAX_BLOCKS)-1:0] rd_addr
);

  localparam int IDX_W = $clog2(MAX_BLOCKS);
  localparam int CNT_W = $clog2(MAX_BLOCKS + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  state_t             state;
  logic [IDX_W-1:0]   cnt;
  logic [CNT_W-1:0]   last;
  logic [31:0]        bu_ext;
  logic [CNT_W-1:0]   limit_sat;
  logic               accept;

  assign accept = s_tvalid && s_tready;
  assign bu_ext = 32'(blocks_in_use);
  // counts above the table size saturate
  assign limit_sat = (bu_ext > 32'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS) : CNT_W'(bu_ext);

  assign cmd.load_wr   = accept && (s_tuser == bfbp_pkg::MODE_LOAD);
  assign cmd.req_start = accept && (s_tuser == bfbp_pkg::MODE_REQ);
  assign cmd.rd_en     = (state == ST_SCAN);
  assign cmd.finish    = (state == ST_FINISH) && stat.out_free;
  assign rd_addr       = cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      s_tready <= 1'b0;
      cnt      <= '0;
      last     <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          s_tready <= 1'b1;
          if (accept && s_tuser == bfbp_pkg::MODE_REQ) begin
            s_tready <= 1'b0;
            cnt      <= '0;
            last     <= limit_sat - CNT_W'(1);
            // nothing to search when no block is in use
            state    <= (limit_sat == '0) ? ST_FINISH : ST_SCAN;
          end
        end
        ST_SCAN: begin
          cnt <= cnt + IDX_W'(1);
          if (CNT_W'(cnt) == last) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          state <= ST_FINISH;
        end
        ST_FINISH: begin
          if (stat.out_free) begin
            state    <= ST_IDLE;
            s_tready <= 1'b1;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `ASSERT_IMP(a_scan_in_range, state == ST_SCAN, CNT_W'(cnt) <= last)
  `ASSERT_NXT(a_req_blocks_input, cmd.req_start, !s_tready)
  `ASSERT_NXT(a_finish_holds, state == ST_FINISH && !stat.out_free, state == ST_FINISH)

endmodule

>>> rtl/core/bfbp_dp.sv
// ----------------------------------------------------------------------------
// bfbp_dp
// Free-size table, best-fit comparator and result register
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bfbp_dp #(
  parameter int MAX_BLOCKS = 16,
  parameter int SIZE_BITS  = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  bfbp_pkg::cmd_t                cmd,
  input  logic [$clog2(MAX_BLOCKS)-1:0] rd_addr,
  input  logic [bfbp_pkg::TDATA_W-1:0]  s_tdata,
  output bfbp_pkg::stat_t               stat,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [bfbp_pkg::TDATA_W-1:0]  m_tdata,
  output logic                          m_tuser
);

  localparam int IDX_W = $clog2(MAX_BLOCKS);

  logic [SIZE_BITS-1:0] mem [MAX_BLOCKS];

  logic [bfbp_pkg::INDEX_W-1:0]  in_index;
  logic [bfbp_pkg::AMOUNT_W-1:0] in_amount;
  logic [SIZE_BITS-1:0]          in_size;

  logic [SIZE_BITS-1:0] req_amount;
  logic [SIZE_BITS-1:0] rd_data;
  logic [IDX_W-1:0]     rd_idx;
  logic                 rd_vld;
  logic                 have;
  logic [IDX_W-1:0]     best_idx;
  logic [SIZE_BITS-1:0] best_size;
  logic [SIZE_BITS-1:0] remain;
  logic                 load_ok;
  logic                 wr_en;
  logic [IDX_W-1:0]     wr_addr;
  logic [SIZE_BITS-1:0] wr_data;
  logic                 better;

  logic [bfbp_pkg::INDEX_W-1:0]  out_index;
  logic [bfbp_pkg::AMOUNT_W-1:0] out_left;

  assign in_index  = s_tdata[bfbp_pkg::INDEX_W-1:0];
  assign in_amount = s_tdata[bfbp_pkg::INDEX_W +: bfbp_pkg::AMOUNT_W];
  assign in_size   = SIZE_BITS'(in_amount);

  assign remain  = best_size - req_amount;
  // loads past the table are dropped
  assign load_ok = 32'(in_index) < 32'(MAX_BLOCKS);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = best_idx;
    wr_data = remain;
    if (cmd.load_wr) begin
      wr_en   = load_ok;
      wr_addr = IDX_W'(in_index);
      wr_data = in_size;
    end else if (cmd.finish) begin
      wr_en = have;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // fits and strictly smaller keeps the lowest index on ties
  assign better = (req_amount <= rd_data) && (!have || rd_data < best_size);

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
      have   <= 1'b0;
    end else begin
      rd_vld <= cmd.rd_en;
      if (cmd.req_start) begin
        have <= 1'b0;
      end else if (rd_vld && better) begin
        have <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx <= rd_addr;
    if (cmd.req_start) begin
      req_amount <= in_size;
    end
    if (rd_vld && better) begin
      best_idx  <= rd_idx;
      best_size <= rd_data;
    end
  end

  // result register, parts the scan from the output stall
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.finish) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      m_tuser   <= have;
      out_index <= have ? bfbp_pkg::INDEX_W'(best_idx) : '0;
      out_left  <= have ? bfbp_pkg::AMOUNT_W'(remain) : '0;
    end
  end

  assign m_tdata = {{bfbp_pkg::TDATA_PAD{1'b0}}, out_left, out_index};
  assign stat.out_free = !m_tvalid || m_tready;

  `ASSERT_NXT(a_finish_loads_out, cmd.finish, m_tvalid)
  `ASSERT_IMP(a_not_found_zero, m_tvalid && !m_tuser, m_tdata == '0)
  `ASSERT_IMP(a_best_fits, have, req_amount <= best_size)

endmodule

>>> rtl/core/best_fit_block_placer_unit.sv
// A load beat writes the table; loads stream at one per cycle while no request is in progress.
// A request scans the L = min(blocks_in_use, MAX_BLOCKS) entries through one read port
// and one comparator; its result then passes a drain state and a finish state into the
// output register (only the finish state if L is 0). The input is ready again once the
// result is registered; a full output register that holds the result back delays both.
// Reset (rst, synchronous) clears control, sets blocks_in_use to 16, leaves the table unset.
// ----------------------------------------------------------------------------
// best_fit_block_placer_unit
// Best-fit placement over a table of block free sizes, apb configured
// ----------------------------------------------------------------------------
module best_fit_block_placer_unit #(
  parameter int MAX_BLOCKS = 16,
  parameter int SIZE_BITS  = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  // input stream
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [bfbp_pkg::TDATA_W-1:0]  s_tdata,  // load_index[3:0], amount[19:4], zero pad
  input  logic                          s_tuser,  // mode
  // result stream
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [bfbp_pkg::TDATA_W-1:0]  m_tdata,  // placed_index[3:0], left_over[19:4], zero pad
  output logic                          m_tuser,  // found
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bfbp_pkg::APB_AW-1:0]   paddr,
  input  logic [bfbp_pkg::APB_DW-1:0]   pwdata,
  output logic [bfbp_pkg::APB_DW-1:0]   prdata,
  output logic                          pready
);

  localparam int IDX_W = $clog2(MAX_BLOCKS);

  logic [bfbp_pkg::CFG_W-1:0] blocks_in_use;
  logic                       reg_hit;
  bfbp_pkg::cmd_t             cmd;
  bfbp_pkg::stat_t            stat;
  logic [IDX_W-1:0]           rd_addr;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[2] == bfbp_pkg::REG_IDX_BLOCKS);

  always_ff @(posedge clk) begin
    if (rst) begin
      blocks_in_use <= bfbp_pkg::BLOCKS_RESET;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      blocks_in_use <= pwdata[bfbp_pkg::CFG_W-1:0];
    end
  end

  assign prdata = reg_hit ? bfbp_pkg::APB_DW'(blocks_in_use) : '0;

  bfbp_ctrl #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tuser       (s_tuser),
    .s_tready      (s_tready),
    .blocks_in_use (blocks_in_use),
    .stat          (stat),
    .cmd           (cmd),
    .rd_addr       (rd_addr)
  );

  bfbp_dp #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .SIZE_BITS  (SIZE_BITS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .rd_addr  (rd_addr),
    .s_tdata  (s_tdata),
    .stat     (stat),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule
